// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CRSL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CRSL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/crsl_pkg.sv =====
// Shared types and constants of the call rate statistics limiter.
package crsl_pkg;

  localparam int COUNT_BITS_DEF = 32;

  localparam int SEC_SLOTS  = 60;
  localparam int MIN_SLOTS  = 60;
  localparam int HOUR_SLOTS = 24;
  localparam int SEC_AW     = $clog2(SEC_SLOTS);
  localparam int MIN_AW     = $clog2(MIN_SLOTS);
  localparam int HOUR_AW    = $clog2(HOUR_SLOTS);
  localparam int STAMP_W    = 32;

  localparam int REQ_W = 3;
  localparam logic [REQ_W-1:0] REQ_INIT  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_TICK  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_EVENT = 3'd2;
  localparam logic [REQ_W-1:0] REQ_CHECK = 3'd3;
  localparam logic [REQ_W-1:0] REQ_READ  = 3'd4;

  localparam logic [1:0] RING_SEC  = 2'd0;
  localparam logic [1:0] RING_MIN  = 2'd1;
  localparam logic [1:0] RING_HOUR = 2'd2;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_CPS_LIMIT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_LIMIT = 2'd1;
  localparam logic [15:0] CPS_LIMIT_RST   = 16'd100;
  localparam logic [15:0] QUEUE_LIMIT_RST = 16'd1000;

  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 120;

  // Exact reciprocals: n / 15 for n below 2**30, and n / 3 for n below 2**18.
  localparam logic [30:0] DIV15_MUL = 31'd1145324613;
  localparam int          DIV15_SH  = 34;
  localparam logic [18:0] DIV3_MUL  = 19'd349526;
  localparam int          DIV3_SH   = 20;

  typedef struct packed {
    logic load;
    logic div1;
    logic div2;
    logic div3;
    logic rd;
    logic upd;
    logic out_load;
  } crsl_cmd_t;

  typedef struct packed {
    logic out_free;
  } crsl_sts_t;

endpackage

// ===== design/crsl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module crsl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/crsl_ctrl.sv =====
// Sequencing state machine of the call rate statistics limiter.
module crsl_ctrl import crsl_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic [REQ_W-1:0] in_tuser,
  output logic             in_tready,
  input  crsl_sts_t        sts,
  output crsl_cmd_t        cmd
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DIV1   = 7'b0000010,
    S_DIV2   = 7'b0000100,
    S_DIV3   = 7'b0001000,
    S_READ   = 7'b0010000,
    S_UPDATE = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   tick_r, tick_nxt;

  always_comb begin
    state_nxt = state_r;
    tick_nxt  = tick_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load = 1'b1;
          tick_nxt = (in_tuser == REQ_TICK);
          if (in_tuser inside {REQ_INIT, REQ_TICK}) begin
            state_nxt = S_DIV1;
          end else if (in_tuser inside {REQ_EVENT, REQ_CHECK, REQ_READ}) begin
            state_nxt = S_READ;
          end else begin
            state_nxt = S_UPDATE;
          end
        end
      end
      S_DIV1: begin
        cmd.div1  = 1'b1;
        state_nxt = S_DIV2;
      end
      S_DIV2: begin
        cmd.div2  = 1'b1;
        state_nxt = S_DIV3;
      end
      S_DIV3: begin
        cmd.div3  = 1'b1;
        state_nxt = tick_r ? S_READ : S_UPDATE;
      end
      S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.upd   = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      tick_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      tick_r  <= tick_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

endmodule

// ===== design/crsl_dp.sv =====
// Datapath: slot rings, time index divider, admission test and result register.
module crsl_dp import crsl_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  crsl_cmd_t              cmd,
  output crsl_sts_t              sts,
  input  logic [REQ_W-1:0]       in_tuser,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   cfg_valid,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [15:0]            cfg_data,
  input  logic                   out_tready,
  output logic                   out_tvalid,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int CNT2_W = 2 * COUNT_BITS;
  localparam int SEC_W  = STAMP_W + CNT2_W;
  localparam int CMP_W  = COUNT_BITS + 16;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  // Latched request.
  logic [REQ_W-1:0] req_r;
  logic [31:0]      now_r;
  logic             offering_r;
  logic [15:0]      pending_r;
  logic [1:0]       ring_r;
  logic [5:0]       slot_r;

  // Configuration.
  logic [15:0] cps_limit_r;
  logic [15:0] queue_limit_r;

  // Divider stages.
  logic [60:0]         p1_r;
  logic [26:0]         q60_r;
  logic [SEC_AW-1:0]   sec_r;
  logic [55:0]         p2_r;
  logic [20:0]         q3600_r;
  logic [MIN_AW-1:0]   min_r;
  logic [36:0]         p3_r;
  logic [26:0]         q60;
  logic [31:0]         sec_full;
  logic [20:0]         q3600;
  logic [26:0]         min_full;
  logic [15:0]         d24;
  logic [20:0]         hour_full;
  logic [HOUR_AW-1:0]  hour_v;

  // Current indices and queue shadow.
  logic [SEC_AW-1:0]  cur_sec_r, cur_sec_nxt;
  logic [MIN_AW-1:0]  cur_min_r, cur_min_nxt;
  logic [HOUR_AW-1:0] cur_hour_r, cur_hour_nxt;
  logic [15:0]        latched_r, latched_nxt;

  // Rings and their valid bits.
  logic [SEC_SLOTS-1:0]  sec_vld_r;
  logic [MIN_SLOTS-1:0]  min_vld_r;
  logic [HOUR_SLOTS-1:0] hour_vld_r;
  logic                  sec_rv_r, min_rv_r, hour_rv_r;

  logic [SEC_AW-1:0]  sec_raddr, sec_waddr;
  logic [MIN_AW-1:0]  min_raddr, min_waddr;
  logic [HOUR_AW-1:0] hour_raddr, hour_waddr;
  logic               sec_we, min_we, hour_we;
  logic [SEC_W-1:0]   sec_wdata, sec_rdata, sec_row;
  logic [CNT2_W-1:0]  min_wdata, min_rdata, min_row;
  logic [CNT2_W-1:0]  hour_wdata, hour_rdata, hour_row;

  logic [COUNT_BITS-1:0] sec_su, sec_dr, min_su, min_dr, hour_su, hour_dr;
  logic [STAMP_W-1:0]    sec_st;
  logic                  drop_rate, drop_queue, check_drop;

  // Result register.
  logic        res_drop_r, res_drop_nxt;
  logic [31:0] res_su_r, res_su_nxt;
  logic [31:0] res_dr_r, res_dr_nxt;
  logic [31:0] res_st_r, res_st_nxt;

  logic                   out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;

  // now / 60, then / 60 again, then mod 24, with one multiplier per stage.
  assign q60       = p1_r[60:DIV15_SH];
  assign sec_full  = now_r - (32'(q60) << 6) + (32'(q60) << 2);
  assign q3600     = p2_r[54:DIV15_SH];
  assign min_full  = q60_r - (27'(q3600) << 6) + (27'(q3600) << 2);
  assign d24       = p3_r[35:DIV3_SH];
  assign hour_full = q3600_r - (21'(d24) << 4) - (21'(d24) << 3);
  assign hour_v    = hour_full[HOUR_AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r      <= in_tuser;
      now_r      <= in_tdata[31:0];
      offering_r <= in_tdata[32];
      pending_r  <= in_tdata[48:33];
      ring_r     <= in_tdata[50:49];
      slot_r     <= in_tdata[56:51];
    end
    if (cmd.div1) begin
      p1_r <= 61'(now_r[31:2]) * 61'(DIV15_MUL);
    end
    if (cmd.div2) begin
      q60_r <= q60;
      sec_r <= sec_full[SEC_AW-1:0];
      p2_r  <= 56'(q60[26:2]) * 56'(DIV15_MUL);
    end
    if (cmd.div3) begin
      q3600_r <= q3600;
      min_r   <= min_full[MIN_AW-1:0];
      p3_r    <= 37'(q3600[20:3]) * 37'(DIV3_MUL);
    end
  end

  // Read addresses: the new second slot for a tick, the requested slot for a
  // read, otherwise the current slot of each ring.
  always_comb begin
    sec_raddr = cur_sec_r;
    if (req_r == REQ_TICK) begin
      sec_raddr = sec_r;
    end else if (req_r == REQ_READ) begin
      sec_raddr = slot_r;
    end
    min_raddr  = (req_r == REQ_READ) ? slot_r : cur_min_r;
    hour_raddr = (req_r == REQ_READ) ? slot_r[HOUR_AW-1:0] : cur_hour_r;
  end

  // A slot never written since reset reads as zero.
  assign sec_row  = sec_rv_r  ? sec_rdata  : '0;
  assign min_row  = min_rv_r  ? min_rdata  : '0;
  assign hour_row = hour_rv_r ? hour_rdata : '0;
  assign sec_su   = sec_row[COUNT_BITS-1:0];
  assign sec_dr   = sec_row[CNT2_W-1:COUNT_BITS];
  assign sec_st   = sec_row[SEC_W-1:CNT2_W];
  assign min_su   = min_row[COUNT_BITS-1:0];
  assign min_dr   = min_row[CNT2_W-1:COUNT_BITS];
  assign hour_su  = hour_row[COUNT_BITS-1:0];
  assign hour_dr  = hour_row[CNT2_W-1:COUNT_BITS];

  assign drop_rate  = CMP_W'(sec_su) > CMP_W'(cps_limit_r);
  assign drop_queue = pending_r > queue_limit_r;
  assign check_drop = drop_rate || drop_queue;

  always_comb begin
    sec_we       = 1'b0;
    sec_waddr    = cur_sec_r;
    sec_wdata    = {sec_st, sec_dr, sec_su};
    min_we       = 1'b0;
    min_waddr    = cur_min_r;
    min_wdata    = {min_dr, min_su};
    hour_we      = 1'b0;
    hour_waddr   = cur_hour_r;
    hour_wdata   = {hour_dr, hour_su};
    cur_sec_nxt  = cur_sec_r;
    cur_min_nxt  = cur_min_r;
    cur_hour_nxt = cur_hour_r;
    latched_nxt  = latched_r;
    res_drop_nxt = res_drop_r;
    res_su_nxt   = res_su_r;
    res_dr_nxt   = res_dr_r;
    res_st_nxt   = res_st_r;
    if (cmd.upd) begin
      res_drop_nxt = 1'b0;
      res_su_nxt   = '0;
      res_dr_nxt   = '0;
      res_st_nxt   = '0;
      case (req_r)
        REQ_INIT: begin
          cur_sec_nxt  = sec_r;
          cur_min_nxt  = min_r;
          cur_hour_nxt = hour_v;
        end
        REQ_TICK: begin
          cur_sec_nxt = sec_r;
          // A stale stamp restarts the slot; a second wrap also restarts the
          // minute slot, and a minute wrap the hour slot.
          if (sec_st != now_r) begin
            sec_we    = 1'b1;
            sec_waddr = sec_r;
            sec_wdata = {now_r, CNT2_W'(0)};
            if (sec_r < cur_sec_r) begin
              cur_min_nxt = min_r;
              min_we      = 1'b1;
              min_waddr   = min_r;
              min_wdata   = '0;
              if (min_r < cur_min_r) begin
                cur_hour_nxt = hour_v;
                hour_we      = 1'b1;
                hour_waddr   = hour_v;
                hour_wdata   = '0;
              end
            end
          end
        end
        REQ_EVENT: begin
          if (offering_r) begin
            sec_we     = 1'b1;
            sec_wdata  = {sec_st, sec_dr, sat_inc(sec_su)};
            min_we     = 1'b1;
            min_wdata  = {min_dr, sat_inc(min_su)};
            hour_we    = 1'b1;
            hour_wdata = {hour_dr, sat_inc(hour_su)};
          end
        end
        REQ_CHECK: begin
          // The queue count is sampled only when the rate test passes.
          if (!drop_rate) begin
            latched_nxt = pending_r;
          end
          if (check_drop) begin
            res_drop_nxt = 1'b1;
            sec_we       = 1'b1;
            sec_wdata    = {sec_st, sat_inc(sec_dr), sec_su};
            min_we       = 1'b1;
            min_wdata    = {sat_inc(min_dr), min_su};
            hour_we      = 1'b1;
            hour_wdata   = {sat_inc(hour_dr), hour_su};
          end
        end
        REQ_READ: begin
          case (ring_r)
            RING_SEC: begin
              if (slot_r < 6'(SEC_SLOTS)) begin
                res_su_nxt = 32'(sec_su);
                res_dr_nxt = 32'(sec_dr);
                res_st_nxt = sec_st;
              end
            end
            RING_MIN: begin
              if (slot_r < 6'(MIN_SLOTS)) begin
                res_su_nxt = 32'(min_su);
                res_dr_nxt = 32'(min_dr);
              end
            end
            RING_HOUR: begin
              if (slot_r < 6'(HOUR_SLOTS)) begin
                res_su_nxt = 32'(hour_su);
                res_dr_nxt = 32'(hour_dr);
              end
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  crsl_ram #(.WIDTH(SEC_W), .DEPTH(SEC_SLOTS)) u_sec_ram (
    .clk   (clk),
    .we    (sec_we),
    .waddr (sec_waddr),
    .wdata (sec_wdata),
    .re    (cmd.rd),
    .raddr (sec_raddr),
    .rdata (sec_rdata)
  );

  crsl_ram #(.WIDTH(CNT2_W), .DEPTH(MIN_SLOTS)) u_min_ram (
    .clk   (clk),
    .we    (min_we),
    .waddr (min_waddr),
    .wdata (min_wdata),
    .re    (cmd.rd),
    .raddr (min_raddr),
    .rdata (min_rdata)
  );

  crsl_ram #(.WIDTH(CNT2_W), .DEPTH(HOUR_SLOTS)) u_hour_ram (
    .clk   (clk),
    .we    (hour_we),
    .waddr (hour_waddr),
    .wdata (hour_wdata),
    .re    (cmd.rd),
    .raddr (hour_raddr),
    .rdata (hour_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      sec_rv_r  <= sec_vld_r[sec_raddr];
      min_rv_r  <= min_vld_r[min_raddr];
      hour_rv_r <= hour_vld_r[hour_raddr];
    end
    res_drop_r <= res_drop_nxt;
    res_su_r   <= res_su_nxt;
    res_dr_r   <= res_dr_nxt;
    res_st_r   <= res_st_nxt;
    if (cmd.out_load) begin
      out_tdata_r <= {7'd0, latched_r, res_st_r, res_dr_r, res_su_r, res_drop_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cps_limit_r   <= CPS_LIMIT_RST;
      queue_limit_r <= QUEUE_LIMIT_RST;
      cur_sec_r     <= '0;
      cur_min_r     <= '0;
      cur_hour_r    <= '0;
      latched_r     <= '0;
      sec_vld_r     <= '0;
      min_vld_r     <= '0;
      hour_vld_r    <= '0;
      out_tvalid_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_CPS_LIMIT:   cps_limit_r   <= cfg_data;
          CFG_QUEUE_LIMIT: queue_limit_r <= cfg_data;
          default: begin
          end
        endcase
      end
      cur_sec_r  <= cur_sec_nxt;
      cur_min_r  <= cur_min_nxt;
      cur_hour_r <= cur_hour_nxt;
      latched_r  <= latched_nxt;
      if (sec_we) begin
        sec_vld_r[sec_waddr] <= 1'b1;
      end
      if (min_we) begin
        min_vld_r[min_waddr] <= 1'b1;
      end
      if (hour_we) begin
        hour_vld_r[hour_waddr] <= 1'b1;
      end
      if (cmd.out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  assign sts.out_free = !out_tvalid_r || out_tready;
  assign out_tvalid   = out_tvalid_r;
  assign out_tdata    = out_tdata_r;

endmodule

// ===== design/call_rate_stats_limiter.sv =====
// Call rate statistics limiter: one request in, one result out. Init, tick,
// call events, admission checks and slot reads each take one transfer on the
// input stream and return exactly one transfer on the result stream. An event,
// a check or a read steps through read, update and done states before the next
// input transfer. An init runs the three-stage divide-by-constant pipeline
// that splits the epoch time into second, minute and hour indices before its
// update, a tick runs it before its read, and an unknown request goes
// straight to update. Each ring access is a registered RAM read and an update
// that may write the slot back. A finished result sits in the output register,
// so the next request is taken while it waits. The configuration port is
// always ready; write it only while no request is in progress.
module call_rate_stats_limiter import crsl_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [REQ_W-1:0]       in_tuser,   // req_type
  // now_seconds, is_offering, pending_count, ring_select, slot_index, zero pad
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // call_dropped, slot_setups, slot_drops, slot_stamp, queue_shadow, zero pad
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [15:0]            cfg_data
);

  crsl_cmd_t cmd;
  crsl_sts_t sts;

  assign cfg_ready = 1'b1;

  crsl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  crsl_dp #(.COUNT_BITS(COUNT_BITS)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== design/crsl_checker.sv =====
// Port-level checker of the call rate statistics limiter, bound to the top level.
`include "assert_macros.svh"

module crsl_checker import crsl_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  `CRSL_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")

  `CRSL_ASSERT_NXT(a_one_item, clk, rst_n, in_tvalid && in_tready, !in_tready, "input taken while a request is in progress")

  `CRSL_ASSERT_IMP(a_drop_no_slot, clk, rst_n, out_tvalid && out_tdata[0], out_tdata[96:1] == '0, "dropped call carries slot data")

  `CRSL_ASSERT_IMP(a_rise_busy, clk, rst_n, $rose(out_tvalid), !$past(in_tready), "result appeared without a request in progress")

endmodule

bind call_rate_stats_limiter crsl_checker u_crsl_checker (.*);

// ===== test/tb_call_rate_stats_limiter.sv =====
// Self-checking testbench for the call rate statistics limiter stream block.
module tb_call_rate_stats_limiter;
  import crsl_pkg::*;

  localparam int CLK_HALF       = 6;
  localparam int RESET_CYCLES   = 4;
  localparam int SETTLE_CYCLES  = 8;
  localparam int HOLD_CYCLES    = 300;
  localparam int TIMEOUT_CYCLES = 200000;
  localparam int PHASE_ITEMS    = 125;
  localparam int SECS_PER_MIN   = 60;
  localparam int SECS_PER_HOUR  = 3600;

  // Request codes the block does not define.
  localparam logic [REQ_W-1:0] REQ_SPARE_A = 3'd5;
  localparam logic [REQ_W-1:0] REQ_SPARE_B = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE_C = 3'd7;
  localparam logic [1:0]       RING_NONE   = 2'd3;

  // Field order matches out_tdata from the top bit down to bit 0.
  typedef struct packed {
    logic [15:0] queue;
    logic [31:0] stamp;
    logic [31:0] drops;
    logic [31:0] setups;
    logic        dropped;
  } limiter_reply_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [REQ_W-1:0]       in_tuser = '0;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [15:0]            cfg_data = '0;

  call_rate_stats_limiter dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Local copy of the limiter state.
  logic [31:0]         sec_calls   [SEC_SLOTS];
  logic [31:0]         sec_rejects [SEC_SLOTS];
  logic [31:0]         sec_stamp   [SEC_SLOTS];
  logic [31:0]         min_calls   [MIN_SLOTS];
  logic [31:0]         min_rejects [MIN_SLOTS];
  logic [31:0]         hr_calls    [HOUR_SLOTS];
  logic [31:0]         hr_rejects  [HOUR_SLOTS];
  logic [SEC_AW-1:0]   sec_idx = '0;
  logic [MIN_AW-1:0]   min_idx = '0;
  logic [HOUR_AW-1:0]  hr_idx = '0;
  logic [15:0]         queue_seen = '0;
  logic [15:0]         lim_cps = CPS_LIMIT_RST;
  logic [15:0]         lim_queue = QUEUE_LIMIT_RST;

  limiter_reply_t replies_due[$];
  int unsigned    mismatches = 0;
  int unsigned    idle_pct = 0;
  int unsigned    stall_pct = 0;
  int unsigned    out_hold_req = 0;
  int unsigned    hold_left = 0;
  logic [31:0]    clock_cursor = 32'd86330;

  initial begin
    for (int i = 0; i < SEC_SLOTS; i++) begin
      sec_calls[i] = '0;
      sec_rejects[i] = '0;
      sec_stamp[i] = '0;
      min_calls[i] = '0;
      min_rejects[i] = '0;
    end
    for (int i = 0; i < HOUR_SLOTS; i++) begin
      hr_calls[i] = '0;
      hr_rejects[i] = '0;
    end
  end

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  initial begin
    #(TIMEOUT_CYCLES * 2 * CLK_HALF);
    $display("FAILED: results differ");
    $finish;
  end

  function automatic logic [31:0] bump(logic [31:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction

  // Applies one accepted request to the local state and returns the reply it owes.
  function automatic limiter_reply_t limiter_outcome(logic [REQ_W-1:0] req, logic [31:0] now,
                                                     logic offering, logic [15:0] pending,
                                                     logic [1:0] ring, logic [5:0] slot);
    limiter_reply_t   r;
    logic [SEC_AW-1:0] old_sec;
    logic [MIN_AW-1:0] old_min;
    logic              reject;
    r = '0;
    reject = 1'b0;
    case (req)
      REQ_INIT: begin
        sec_idx = SEC_AW'(now % SEC_SLOTS);
        min_idx = MIN_AW'((now / SECS_PER_MIN) % MIN_SLOTS);
        hr_idx  = HOUR_AW'((now / SECS_PER_HOUR) % HOUR_SLOTS);
      end
      REQ_TICK: begin
        old_sec = sec_idx;
        sec_idx = SEC_AW'(now % SEC_SLOTS);
        // A stale stamp clears the slot; a wrap of the second index rolls the minute
        // ring, and a wrap of the minute index rolls the hour ring.
        if (sec_stamp[sec_idx] != now) begin
          sec_calls[sec_idx] = '0;
          sec_rejects[sec_idx] = '0;
          sec_stamp[sec_idx] = now;
          if (sec_idx < old_sec) begin
            old_min = min_idx;
            min_idx = MIN_AW'((now / SECS_PER_MIN) % MIN_SLOTS);
            min_calls[min_idx] = '0;
            min_rejects[min_idx] = '0;
            if (min_idx < old_min) begin
              hr_idx = HOUR_AW'((now / SECS_PER_HOUR) % HOUR_SLOTS);
              hr_calls[hr_idx] = '0;
              hr_rejects[hr_idx] = '0;
            end
          end
        end
      end
      REQ_EVENT: begin
        if (offering) begin
          sec_calls[sec_idx] = bump(sec_calls[sec_idx]);
          min_calls[min_idx] = bump(min_calls[min_idx]);
          hr_calls[hr_idx]   = bump(hr_calls[hr_idx]);
        end
      end
      REQ_CHECK: begin
        if (sec_calls[sec_idx] > {16'd0, lim_cps}) begin
          reject = 1'b1;
        end else begin
          queue_seen = pending;
          reject = (pending > lim_queue);
        end
        if (reject) begin
          sec_rejects[sec_idx] = bump(sec_rejects[sec_idx]);
          min_rejects[min_idx] = bump(min_rejects[min_idx]);
          hr_rejects[hr_idx]   = bump(hr_rejects[hr_idx]);
        end
        r.dropped = reject;
      end
      REQ_READ: begin
        if (ring == RING_SEC && slot < SEC_SLOTS) begin
          r.setups = sec_calls[slot];
          r.drops  = sec_rejects[slot];
          r.stamp  = sec_stamp[slot];
        end else if (ring == RING_MIN && slot < MIN_SLOTS) begin
          r.setups = min_calls[slot];
          r.drops  = min_rejects[slot];
        end else if (ring == RING_HOUR && slot < HOUR_SLOTS) begin
          r.setups = hr_calls[slot];
          r.drops  = hr_rejects[slot];
        end
      end
      default: ;
    endcase
    r.queue = queue_seen;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Result checker: every transfer on the result stream is matched to the oldest reply due.
  always @(posedge clk) begin
    limiter_reply_t want;
    limiter_reply_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = limiter_reply_t'(out_tdata[$bits(limiter_reply_t)-1:0]);
      if (replies_due.size() == 0) begin
        $error("unexpected result transfer, tdata %h", out_tdata);
        mismatches++;
      end else begin
        want = replies_due.pop_front();
        check_field("call_dropped", 32'(want.dropped), 32'(got.dropped));
        check_field("slot_setups", want.setups, got.setups);
        check_field("slot_drops", want.drops, got.drops);
        check_field("slot_stamp", want.stamp, got.stamp);
        check_field("queue_shadow", 32'(want.queue), 32'(got.queue));
      end
    end
  end

  // Result stream ready: random stalls, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (out_hold_req != 0) begin
      hold_left = out_hold_req;
      out_hold_req = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_request(input logic [REQ_W-1:0] req, input logic [31:0] now,
                              input logic offering, input logic [15:0] pending,
                              input logic [1:0] ring, input logic [5:0] slot);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {7'd0, slot, ring, pending, offering, now};
    do @(posedge clk); while (!in_tready);
    replies_due.push_back(limiter_outcome(req, now, offering, pending, ring, slot));
  endtask

  // Stops sending and lets every owed result come back before the block is touched again.
  task automatic wait_all_results();
    in_tvalid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limits(input logic [15:0] cps, input logic [15:0] qlim);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_CPS_LIMIT;
    cfg_data  <= cps;
    do @(posedge clk); while (!cfg_ready);
    lim_cps = cps;
    cfg_index <= CFG_QUEUE_LIMIT;
    cfg_data  <= qlim;
    do @(posedge clk); while (!cfg_ready);
    lim_queue = qlim;
    cfg_valid <= 1'b0;
  endtask

  // Mostly time moving forward with calls, checks and reads; some jumps back and noise.
  task automatic run_random_traffic(input int count);
    logic [REQ_W-1:0] req;
    logic [31:0]      now;
    logic             offering;
    logic [15:0]      pending;
    logic [1:0]       ring;
    logic [5:0]       slot;
    int unsigned      pick;
    int unsigned      r;
    for (int k = 0; k < count; k++) begin
      now      = $urandom;
      offering = 1'($urandom_range(1));
      pending  = 16'($urandom);
      ring     = 2'($urandom);
      slot     = 6'($urandom);
      pick     = $urandom_range(99);
      r        = $urandom_range(99);
      if (pick < 8) begin
        req = REQ_TICK;
        if (r < 70) clock_cursor = clock_cursor + 32'd1;
        else if (r < 80) clock_cursor = clock_cursor;
        else if (r < 90) clock_cursor = clock_cursor + $urandom_range(2, 200);
        else if (r < 96) clock_cursor = clock_cursor + $urandom_range(3000, 4000);
        else clock_cursor = now;
        now = clock_cursor;
      end else if (pick < 11) begin
        req = REQ_INIT;
        if (r < 50) clock_cursor = now;
        now = clock_cursor;
      end else if (pick < 46) begin
        req = REQ_EVENT;
        offering = (r < 85);
      end else if (pick < 76) begin
        req = REQ_CHECK;
        if (r < 33) pending = 16'($urandom_range(0, 2000));
        else if (r < 66) pending = 16'(lim_queue + $urandom_range(0, 2) - 1);
      end else if (pick < 97) begin
        req = REQ_READ;
        ring = ($urandom_range(99) < 85) ? 2'($urandom_range(RING_SEC, RING_HOUR)) : RING_NONE;
        if (r < 70) begin
          slot = 6'($urandom_range(0, (ring == RING_HOUR) ? HOUR_SLOTS - 1 : SEC_SLOTS - 1));
        end else if (r < 85) begin
          slot = (ring == RING_SEC) ? sec_idx : (ring == RING_MIN) ? min_idx : 6'(hr_idx);
        end
      end else begin
        req = REQ_W'($urandom_range(REQ_SPARE_A, REQ_SPARE_C));
      end
      send_request(req, now, offering, pending, ring, slot);
    end
  endtask

  task automatic test_reset_reads();
    send_request(REQ_READ, '0, 1'b0, '0, RING_SEC, 6'd0);
    send_request(REQ_READ, '0, 1'b0, '0, RING_NONE, 6'd0);
    send_request(REQ_READ, '0, 1'b0, '0, RING_SEC, 6'd63);
    send_request(REQ_READ, '0, 1'b0, '0, RING_MIN, 6'(MIN_SLOTS));
    send_request(REQ_READ, '0, 1'b0, '0, RING_HOUR, 6'(HOUR_SLOTS));
    send_request(REQ_READ, '1, 1'b1, '1, RING_HOUR, 6'(HOUR_SLOTS - 1));
    send_request(REQ_SPARE_A, '1, 1'b1, '1, RING_NONE, '1);
    send_request(REQ_SPARE_B, '1, 1'b1, '1, RING_NONE, '1);
    send_request(REQ_SPARE_C, '1, 1'b1, '1, RING_NONE, '1);
  endtask

  // Default limits: the queue test sits right at its boundary.
  task automatic test_default_checks();
    send_request(REQ_TICK, '0, 1'b0, '0, RING_SEC, '0);
    send_request(REQ_EVENT, '0, 1'b0, '0, RING_SEC, '0);
    send_request(REQ_EVENT, '0, 1'b1, '0, RING_SEC, '0);
    send_request(REQ_CHECK, '0, 1'b0, QUEUE_LIMIT_RST, RING_SEC, '0);
    send_request(REQ_CHECK, '0, 1'b0, QUEUE_LIMIT_RST + 16'd1, RING_SEC, '0);
    send_request(REQ_CHECK, '0, 1'b0, 16'hFFFF, RING_SEC, '0);
    send_request(REQ_READ, '0, 1'b0, '0, RING_SEC, 6'd0);
  endtask

  // Last second of a day, then the tick that rolls all three rings.
  task automatic test_window_wraps();
    send_request(REQ_INIT, 32'd86399, 1'b0, '0, RING_SEC, '0);
    send_request(REQ_TICK, 32'd86399, 1'b0, '0, RING_SEC, '0);
    send_request(REQ_EVENT, '0, 1'b1, '0, RING_SEC, '0);
    send_request(REQ_TICK, 32'd86400, 1'b0, '0, RING_SEC, '0);
    send_request(REQ_TICK, 32'd86400, 1'b0, '0, RING_SEC, '0);
    send_request(REQ_READ, '0, 1'b0, '0, RING_HOUR, 6'd23);
    send_request(REQ_READ, '0, 1'b0, '0, RING_MIN, 6'd59);
    send_request(REQ_READ, '0, 1'b0, '0, RING_SEC, 6'd59);
    send_request(REQ_INIT, 32'hFFFF_FFFF, 1'b0, '0, RING_SEC, '0);
    send_request(REQ_TICK, 32'hFFFF_FFFF, 1'b0, '0, RING_SEC, '0);
    send_request(REQ_READ, '0, 1'b0, '0, RING_SEC, sec_idx);
  endtask

  task automatic test_limit_extremes();
    wait_all_results();
    write_limits(16'd0, 16'd0);
    send_request(REQ_EVENT, '0, 1'b1, '0, RING_SEC, '0);
    send_request(REQ_CHECK, '0, 1'b0, 16'd5, RING_SEC, '0);
    wait_all_results();
    write_limits(16'hFFFF, 16'hFFFF);
    send_request(REQ_CHECK, '0, 1'b0, 16'hFFFF, RING_SEC, '0);
    send_request(REQ_CHECK, '0, 1'b0, 16'd0, RING_SEC, '0);
    send_request(REQ_READ, '0, 1'b0, '0, RING_MIN, min_idx);
  endtask

  // The result stream holds off while requests keep coming, so the input backs up.
  task automatic test_output_stall();
    wait_all_results();
    idle_pct = 0;
    stall_pct = 0;
    out_hold_req = HOLD_CYCLES;
    run_random_traffic(30);
    wait_all_results();
  endtask

  task automatic test_random_phase(input int unsigned idle, input int unsigned stall,
                                   input logic [15:0] cps, input logic [15:0] qlim);
    wait_all_results();
    write_limits(cps, qlim);
    idle_pct = idle;
    stall_pct = stall;
    run_random_traffic(PHASE_ITEMS);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_reads();
    test_default_checks();
    test_window_wraps();
    test_limit_extremes();
    test_output_stall();
    test_random_phase(0, 0, 16'd3, 16'd32768);
    test_random_phase(53, 0, 16'd0, 16'hFFFF);
    test_random_phase(0, 53, 16'hFFFF, 16'd0);
    test_random_phase(35, 35, 16'd8, QUEUE_LIMIT_RST);
    wait_all_results();
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
